/* src/i2cms_pkg.sv */
// Package for the I2C master transaction sequencer.
// Holds function, action and status codes, widths and the word types.
// No dependencies.
package i2cms_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int LEN_W     = 6;
	localparam int OQ_DEPTH  = 3;
	localparam int OQ_AW     = 2;

	localparam logic [2:0] FN_START_RD = 3'd0;
	localparam logic [2:0] FN_START_WR = 3'd1;
	localparam logic [2:0] FN_EVENT    = 3'd2;
	localparam logic [2:0] FN_LOAD     = 3'd3;
	localparam logic [2:0] FN_READ     = 3'd4;

	localparam logic [2:0] ACT_NONE  = 3'd0;
	localparam logic [2:0] ACT_SEND  = 3'd1;
	localparam logic [2:0] ACT_START = 3'd2;
	localparam logic [2:0] ACT_RECV  = 3'd3;
	localparam logic [2:0] ACT_STOP  = 3'd4;

	localparam logic [7:0] ST_START         = 8'h08;
	localparam logic [7:0] ST_RSTART        = 8'h10;
	localparam logic [7:0] ST_MT_SLA_ACK    = 8'h18;
	localparam logic [7:0] ST_MT_SLA_NACK   = 8'h20;
	localparam logic [7:0] ST_MT_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_MR_SLA_ACK    = 8'h40;
	localparam logic [7:0] ST_MR_SLA_NACK   = 8'h48;
	localparam logic [7:0] ST_MR_DATA_ACK   = 8'h50;
	localparam logic [7:0] ST_MR_DATA_NACK  = 8'h58;

	typedef struct packed {
		logic [2:0]       func;
		logic [7:0]       addr_byte;
		logic [LEN_W-1:0] length;
		logic [7:0]       status_code;
		logic [7:0]       rx_byte;
		logic [4:0]       buf_index;
		logic [7:0]       buf_data;
	} in_word_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] tx_byte;
		logic       ack_next;
		logic       clear_start;
		logic       done_res;
		logic       busy_res;
		logic [7:0] read_data;
	} out_word_t;

	// result of the decode stage; buffer bytes are merged in the following cycle
	typedef struct packed {
		out_word_t w;
		logic      tx_mem;
		logic      rd_mem;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [BUF_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [BUF_AW-1:0] raddr;
	} mem_req_t;

endpackage

/* src/i2cms_buf.sv */
// Data buffer of the sequencer: one write port, one registered read port.
// Depends on i2cms_pkg.
module i2cms_buf (
	input  logic                clk,
	input  i2cms_pkg::mem_req_t req,
	output logic [7:0]          rdata
);
	import i2cms_pkg::*;

	logic [7:0] mem [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

/* src/i2cms_ctrl.sv */
// Transfer state and status decode; registers the decoded result in stage 1.
// Depends on i2cms_pkg.
module i2cms_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  i2cms_pkg::in_word_t din,
	output i2cms_pkg::mem_req_t mreq,
	output i2cms_pkg::res_t     res_s1,
	output logic                valid_s1
);
	import i2cms_pkg::*;

	logic             busy_q, busy_d;
	logic [7:0]       target_q, target_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] pos_q, pos_d;
	res_t             res_d;
	logic             pos_lt_len, pos_in_buf;
	logic [LEN_W:0]   pos_p1, pos_p2;

	assign pos_lt_len = pos_q < len_q;
	assign pos_in_buf = {1'b0, pos_q} < (LEN_W + 1)'(BUF_DEPTH);
	assign pos_p1     = {1'b0, pos_q} + (LEN_W + 1)'(1);
	assign pos_p2     = {1'b0, pos_q} + (LEN_W + 1)'(2);

	always_comb begin
		busy_d   = busy_q;
		target_d = target_q;
		len_d    = len_q;
		pos_d    = pos_q;
		res_d    = '0;
		mreq     = '0;
		mreq.wdata = din.rx_byte;
		mreq.waddr = pos_q[BUF_AW-1:0];
		mreq.raddr = pos_q[BUF_AW-1:0];
		case (din.func)
			FN_START_RD, FN_START_WR: begin
				target_d = (din.func == FN_START_RD) ? (din.addr_byte | 8'h01)
				                                     : (din.addr_byte & 8'hfe);
				len_d = (din.length > LEN_W'(BUF_DEPTH)) ? LEN_W'(BUF_DEPTH) : din.length;
				busy_d = 1'b1;
				res_d.w.action = ACT_START;
			end
			FN_EVENT: begin
				case (din.status_code)
					ST_START, ST_RSTART: begin
						res_d.w.action      = ACT_SEND;
						res_d.w.tx_byte     = target_q;
						res_d.w.clear_start = 1'b1;
						pos_d               = '0;
					end
					ST_MR_DATA_ACK: begin
						if (pos_lt_len) begin
							mreq.we          = pos_in_buf;
							pos_d            = pos_p1[LEN_W-1:0];
							res_d.w.action   = ACT_RECV;
							res_d.w.ack_next = pos_p2 < {1'b0, len_q};
						end else begin
							res_d.w.action = ACT_STOP;
						end
					end
					ST_MR_SLA_ACK: begin
						res_d.w.action   = ACT_RECV;
						res_d.w.ack_next = pos_p1 < {1'b0, len_q};
					end
					ST_MR_SLA_NACK, ST_MT_SLA_NACK: begin
						res_d.w.action = ACT_START;
					end
					ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
						if (pos_lt_len && pos_in_buf) begin
							res_d.w.action = ACT_SEND;
							res_d.tx_mem   = 1'b1;
							mreq.re        = 1'b1;
							pos_d          = pos_p1[LEN_W-1:0];
						end else begin
							res_d.w.action = ACT_STOP;
						end
					end
					ST_MR_DATA_NACK: begin
						mreq.we        = pos_lt_len && pos_in_buf;
						res_d.w.action = ACT_STOP;
					end
					default: begin
						res_d.w.action = ACT_STOP;
					end
				endcase
				if (res_d.w.action == ACT_STOP) begin
					res_d.w.done_res = 1'b1;
					busy_d           = 1'b0;
				end
			end
			FN_LOAD: begin
				mreq.we    = 1'b1;
				mreq.waddr = din.buf_index[BUF_AW-1:0];
				mreq.wdata = din.buf_data;
			end
			FN_READ: begin
				mreq.re      = 1'b1;
				mreq.raddr   = din.buf_index[BUF_AW-1:0];
				res_d.rd_mem = 1'b1;
			end
			default: begin
			end
		endcase
		res_d.w.busy_res = busy_d;
		if (!accept) begin
			mreq.we = 1'b0;
			mreq.re = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			target_q <= '0;
			len_q    <= '0;
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				busy_q   <= busy_d;
				target_q <= target_d;
				len_q    <= len_d;
				pos_q    <= pos_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

endmodule

/* src/i2cms_outq.sv */
// Three-word result queue between stage 1 and the master-side stream.
// Depends on i2cms_pkg.
module i2cms_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  i2cms_pkg::out_word_t din,
	input  logic                 pop_rdy,
	output i2cms_pkg::out_word_t dout,
	output logic                 valid,
	output logic [1:0]           count
);
	import i2cms_pkg::*;

	out_word_t        q_mem [OQ_DEPTH];
	logic [OQ_AW-1:0] wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign valid = cnt_q != 2'd0;
	assign pop   = valid && pop_rdy;
	assign dout  = q_mem[rp_q];
	assign count = cnt_q;

	function automatic logic [OQ_AW-1:0] nxt(input logic [OQ_AW-1:0] p);
		return (p == OQ_AW'(OQ_DEPTH - 1)) ? '0 : p + OQ_AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= nxt(wp_q);
			end
			if (pop) begin
				rp_q <= nxt(rp_q);
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= din;
		end
	end

endmodule

/* src/i2c_master_transaction_sequencer_core.sv */
// A word accepted on s_ passes through the stage-1 register and the result queue before it is offered on m_.
// Throughput: one word per cycle while m_ keeps up; the decode stage and the buffer read port
// each take one word a cycle, and a three-word queue absorbs m_ stalls until s_tready drops.
// Reset: arst_n clears busy, address, length, position and the queue at once.
// Buffer contents are undefined until loaded.
module i2c_master_transaction_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // addr_byte, length, status_code, rx_byte, buf_index, buf_data
	input  logic [2:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // tx_byte, ack_next, clear_start, done_res, busy_res, read_data
	output logic [2:0]  m_tuser    // action
);
	import i2cms_pkg::*;

	in_word_t  din;
	mem_req_t  mreq;
	res_t      res_s1;
	logic      valid_s1;
	logic [7:0] mem_rdata;
	out_word_t merged, qout;
	logic [1:0] q_count;
	logic       accept;
	logic [2:0] fill;

	assign din.func        = s_tuser;
	assign din.addr_byte   = s_tdata[7:0];
	assign din.length      = s_tdata[13:8];
	assign din.status_code = s_tdata[21:14];
	assign din.rx_byte     = s_tdata[29:22];
	assign din.buf_index   = s_tdata[34:30];
	assign din.buf_data    = s_tdata[42:35];

	assign fill     = {1'b0, q_count} + {2'b00, valid_s1};
	assign s_tready = fill <= 3'd2;
	assign accept   = s_tvalid && s_tready;

	i2cms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.din      (din),
		.mreq     (mreq),
		.res_s1   (res_s1),
		.valid_s1 (valid_s1)
	);

	i2cms_buf u_buf (
		.clk   (clk),
		.req   (mreq),
		.rdata (mem_rdata)
	);

	always_comb begin
		merged = res_s1.w;
		if (res_s1.tx_mem) begin
			merged.tx_byte = mem_rdata;
		end
		if (res_s1.rd_mem) begin
			merged.read_data = mem_rdata;
		end
	end

	i2cms_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (valid_s1),
		.din     (merged),
		.pop_rdy (m_tready),
		.dout    (qout),
		.valid   (m_tvalid),
		.count   (q_count)
	);

	assign m_tuser = qout.action;
	assign m_tdata = {4'b0000, qout.read_data, qout.busy_res, qout.done_res,
	                  qout.clear_start, qout.ack_next, qout.tx_byte};

`ifndef NO_ASSERTIONS
	a_stall_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no word queued");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] |-> !m_tdata[11] && m_tuser == ACT_STOP)
		else $error("done without stop or with busy set");
	a_clear_send: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tuser == ACT_SEND)
		else $error("clear_start outside address send");
	a_ack_recv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tuser == ACT_RECV)
		else $error("ack_next outside receive");
`endif

endmodule

/* bench/tb_i2c_master_transaction_sequencer_core.sv */
// Testbench for i2c_master_transaction_sequencer_core: directed and random
// transfers with random stalls, each result word checked against a predictor.
// Depends on i2cms_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_i2c_master_transaction_sequencer_core;
	import i2cms_pkg::*;

	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;
	localparam int ITEM_TARGET = 775;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] KNOWN_CODES [9] = '{ST_START, ST_RSTART, ST_MT_SLA_ACK,
		ST_MT_SLA_NACK, ST_MT_DATA_ACK, ST_MR_SLA_ACK, ST_MR_SLA_NACK, ST_MR_DATA_ACK,
		ST_MR_DATA_NACK};

	class xfer_scoreboard;
		logic             busy;
		logic [7:0]       tgt;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] pos;
		logic [7:0]       data_mem [BUF_DEPTH];
		bit [BUF_DEPTH-1:0] written;
		out_word_t        expected_actions [$];
		int               errors;

		function new();
			busy = 1'b0;
			tgt = '0;
			len = '0;
			pos = '0;
			written = '0;
			errors = 0;
		endfunction

		function void store_rx(logic [7:0] b);
			if (pos < BUF_DEPTH) begin
				data_mem[pos[BUF_AW-1:0]] = b;
				written[pos[BUF_AW-1:0]] = 1'b1;
			end
		endfunction

		function void note_word(in_word_t w);
			out_word_t r;
			r = '0;
			case (w.func)
				FN_START_RD, FN_START_WR: begin
					tgt = (w.func == FN_START_RD) ? (w.addr_byte | 8'h01) : (w.addr_byte & 8'hFE);
					len = (w.length > BUF_DEPTH) ? LEN_W'(BUF_DEPTH) : w.length;
					busy = 1'b1;
					r.action = ACT_START;
				end
				FN_EVENT: begin
					case (w.status_code)
						ST_START, ST_RSTART: begin
							r.action = ACT_SEND;
							r.tx_byte = tgt;
							r.clear_start = 1'b1;
							pos = '0;
						end
						ST_MR_DATA_ACK: begin
							if (pos < len) begin
								store_rx(w.rx_byte);
								pos = pos + LEN_W'(1);
								r.action = ACT_RECV;
								r.ack_next = (int'(pos) + 1 < int'(len));
							end else
								r.action = ACT_STOP;
						end
						ST_MR_SLA_ACK: begin
							r.action = ACT_RECV;
							r.ack_next = (int'(pos) + 1 < int'(len));
						end
						ST_MT_SLA_NACK, ST_MR_SLA_NACK: r.action = ACT_START;
						ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
							if (pos < len && pos < BUF_DEPTH) begin
								r.action = ACT_SEND;
								r.tx_byte = data_mem[pos[BUF_AW-1:0]];
								pos = pos + LEN_W'(1);
							end else
								r.action = ACT_STOP;
						end
						ST_MR_DATA_NACK: begin
							if (pos < len)
								store_rx(w.rx_byte);
							r.action = ACT_STOP;
						end
						default: r.action = ACT_STOP;
					endcase
					if (r.action == ACT_STOP) begin
						r.done_res = 1'b1;
						busy = 1'b0;
					end
				end
				FN_LOAD: begin
					data_mem[w.buf_index] = w.buf_data;
					written[w.buf_index] = 1'b1;
				end
				FN_READ: r.read_data = data_mem[w.buf_index];
				default: ;
			endcase
			r.busy_res = busy;
			expected_actions.push_back(r);
		endfunction

		function void compare(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (expected_actions.size() == 0) begin
				$error("result word with nothing pending: action %0d", got.action);
				errors++;
				return;
			end
			want = expected_actions.pop_front();
			compare("action", 8'(want.action), 8'(got.action));
			compare("tx_byte", want.tx_byte, got.tx_byte);
			compare("ack_next", 8'(want.ack_next), 8'(got.ack_next));
			compare("clear_start", 8'(want.clear_start), 8'(got.clear_start));
			compare("done_res", 8'(want.done_res), 8'(got.done_res));
			compare("busy_res", 8'(want.busy_res), 8'(got.busy_res));
			compare("read_data", want.read_data, got.read_data);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // addr_byte, length, status_code, rx_byte, buf_index, buf_data
	logic [2:0]  s_tuser;   // func
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // tx_byte, ack_next, clear_start, done_res, busy_res, read_data
	logic [2:0]  m_tuser;   // action

	xfer_scoreboard model;
	bit calm;
	int items;
	int cycles = 0;

	i2c_master_transaction_sequencer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_i2c_master_transaction_sequencer_core: FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= 21);

	always @(posedge clk) begin
		out_word_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '0;
			got.action = m_tuser;
			got.tx_byte = m_tdata[7:0];
			got.ack_next = m_tdata[8];
			got.clear_start = m_tdata[9];
			got.done_res = m_tdata[10];
			got.busy_res = m_tdata[11];
			got.read_data = m_tdata[19:12];
			model.check_word(got);
		end
	end

	function automatic in_word_t rand_word();
		in_word_t w;
		w.func = 3'($urandom_range(7));
		w.addr_byte = 8'($urandom_range(255));
		w.length = LEN_W'($urandom_range(63));
		w.status_code = 8'($urandom_range(255));
		w.rx_byte = 8'($urandom_range(255));
		w.buf_index = 5'($urandom_range(31));
		w.buf_data = 8'($urandom_range(255));
		return w;
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(6);
		else if (r < 95)
			return $urandom_range(32, 7);
		return $urandom_range(63, 33);
	endfunction

	task automatic issue(input logic [2:0] f, input in_word_t w);
		w.func = f;
		while (!calm && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, w.buf_data, w.buf_index, w.rx_byte, w.status_code, w.length,
			w.addr_byte};
		s_tuser <= w.func;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model.note_word(w);
		items++;
		@(negedge clk);
	endtask

	task automatic event_code(input logic [7:0] code);
		in_word_t w;
		w = rand_word();
		w.status_code = code;
		issue(FN_EVENT, w);
	endtask

	task automatic start_xfer(input logic [2:0] f, input logic [7:0] addr, input int n);
		in_word_t w;
		w = rand_word();
		w.addr_byte = addr;
		w.length = LEN_W'(n);
		issue(f, w);
	endtask

	task automatic load_byte(input int idx, input logic [7:0] d);
		in_word_t w;
		w = rand_word();
		w.buf_index = 5'(idx);
		w.buf_data = d;
		issue(FN_LOAD, w);
	endtask

	task automatic read_byte(input int idx);
		in_word_t w;
		w = rand_word();
		w.buf_index = 5'(idx);
		issue(FN_READ, w);
	endtask

	task automatic write_xfer();
		int n;
		int top;
		n = pick_len();
		top = (n > BUF_DEPTH) ? BUF_DEPTH : n;
		for (int i = 0; i < top; i++)
			if (!model.written[i] || $urandom_range(2) == 0)
				load_byte(i, 8'($urandom_range(255)));
		start_xfer(FN_START_WR, 8'($urandom_range(255)), n);
		event_code($urandom_range(1) ? ST_START : ST_RSTART);
		if ($urandom_range(7) == 0) begin
			event_code(ST_MT_SLA_NACK);
			event_code(ST_RSTART);
		end
		event_code(ST_MT_SLA_ACK);
		// prefix up to the length is loaded, so any code here is safe
		while (model.busy)
			if ($urandom_range(15) == 0)
				event_code(8'($urandom_range(255)));
			else
				event_code(ST_MT_DATA_ACK);
	endtask

	task automatic read_xfer();
		int idx;
		start_xfer(FN_START_RD, 8'($urandom_range(255)), pick_len());
		event_code(ST_START);
		if ($urandom_range(7) == 0) begin
			event_code(ST_MR_SLA_NACK);
			event_code(ST_RSTART);
		end
		event_code(ST_MR_SLA_ACK);
		while (model.busy)
			if (model.pos < model.len && $urandom_range(9) != 0)
				event_code(ST_MR_DATA_ACK);
			else if ($urandom_range(1))
				event_code(ST_MR_DATA_NACK);
			else
				event_code(ST_MR_DATA_ACK);
		repeat ($urandom_range(3)) begin
			idx = $urandom_range(31);
			if (model.written[idx])
				read_byte(idx);
		end
	endtask

	task automatic noise_item();
		in_word_t w;
		w = rand_word();
		if ($urandom_range(1))
			w.status_code = KNOWN_CODES[$urandom_range(8)];
		// never fetch a buffer entry that was not written
		if (w.func == FN_EVENT && (w.status_code == ST_MT_SLA_ACK ||
				w.status_code == ST_MT_DATA_ACK) && model.pos < model.len &&
				model.pos < BUF_DEPTH && !model.written[model.pos[BUF_AW-1:0]]) begin
			w.func = FN_LOAD;
			w.buf_index = model.pos[BUF_AW-1:0];
		end
		if (w.func == FN_READ && !model.written[w.buf_index])
			w.func = FN_LOAD;
		issue(w.func, w);
	endtask

	initial begin
		int sel;
		model = new();
		calm = 1'b0;
		items = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		load_byte(0, 8'hA5);
		load_byte(31, 8'hFF);
		load_byte(1, 8'h00);
		read_byte(31);
		event_code(8'h00);
		start_xfer(FN_START_WR, 8'hFF, 0);
		event_code(ST_START);
		event_code(ST_MT_SLA_ACK);
		start_xfer(FN_START_RD, 8'h00, 63);
		start_xfer(FN_START_WR, 8'h5A, 2);
		event_code(ST_RSTART);
		event_code(ST_MT_SLA_NACK);
		event_code(ST_START);
		event_code(ST_MT_SLA_ACK);
		event_code(ST_MT_DATA_ACK);
		event_code(ST_MT_DATA_ACK);
		start_xfer(FN_START_RD, 8'hA4, 1);
		event_code(ST_MR_SLA_NACK);
		event_code(ST_START);
		event_code(ST_MR_SLA_ACK);
		event_code(ST_MR_DATA_ACK);
		event_code(ST_MR_DATA_ACK);
		event_code(ST_MR_DATA_NACK);
		issue(FN_SPARE_LO, rand_word());
		issue(FN_SPARE_HI, rand_word());

		while (items < ITEM_TARGET) begin
			calm = (items >= 420 && items < 560);
			sel = $urandom_range(99);
			if (sel < 40)
				write_xfer();
			else if (sel < 80)
				read_xfer();
			else
				repeat ($urandom_range(4, 1)) noise_item();
		end
		s_tvalid <= 1'b0;

		while (model.expected_actions.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (model.errors == 0 && model.expected_actions.size() == 0)
			$display("tb_i2c_master_transaction_sequencer_core: PASS");
		else
			$display("tb_i2c_master_transaction_sequencer_core: FAIL");
		$finish;
	end

endmodule

/* i2c_master_transaction_sequencer_core.f */
src/i2cms_pkg.sv
src/i2cms_buf.sv
src/i2cms_ctrl.sv
src/i2cms_outq.sv
src/i2c_master_transaction_sequencer_core.sv
bench/tb_i2c_master_transaction_sequencer_core.sv
